### hdl/adc_pkg.sv
// shared types, constants and codes for the automatic door controller
package adc_pkg;

    localparam int DUTY_BITS  = 8;
    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [DUTY_BITS-1:0]  DUTY_MAX  = 8'd255;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_UP_STEP      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_DOWN_START  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_DOWN_STEP   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_DOWN_STEP    = 3'd4;

    // configuration reset values
    localparam logic [15:0] HOLD_TIME_RST        = 16'd7000;
    localparam logic [1:0]  RAMP_UP_STEP_RST     = 2'd2;
    localparam logic [7:0]  CLOSE_DOWN_START_RST = 8'd190;
    localparam logic [1:0]  CLOSE_DOWN_STEP_RST  = 2'd1;
    localparam logic [1:0]  OPEN_DOWN_STEP_RST   = 2'd2;

    // door status codes
    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_CLOSED  = 2'd1;
    localparam logic [1:0] MODE_OPENING = 2'd2;
    localparam logic [1:0] MODE_CLOSING = 2'd3;

    // motor ramp phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_DOWN = 2'd2;

    // requested motor direction
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_CLOSE = 2'd1;
    localparam logic [1:0] DIR_OPEN  = 2'd2;

    typedef struct packed {
        logic limit_open_n;
        logic limit_closed_n;
        logic sensor_a;
        logic sensor_b;
    } tick_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] close_drive_duty;
        logic [DUTY_BITS-1:0] open_drive_duty;
        logic [1:0]           door_status;
        logic                 hold_active;
    } result_t;

endpackage

### hdl/adc_tick_if.sv
// valid/ready channels carrying tick items and result items
interface adc_tick_if import adc_pkg::*;;
    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface adc_result_if import adc_pkg::*;;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/auto_door_controller.sv
// automatic door controller: door state, hold timer and motor duty ramps
//
// tick channel: one item per millisecond tick with the two active-low limit
// switches and the two presence sensors. result channel: one item per tick
// with both motor duties, the door status and the hold timer flag.
// cfg port: cfg_wr_en with cfg_index and cfg_data writes one register in a
// cycle; write only while no tick is in flight.
//
// a tick's result is registered at the same edge that accepts the tick.
// throughput: one tick per cycle while result.ready is high or the result
// register is empty; the whole state update is a single pass of logic from
// the tick fields and state into the state and result registers.
// reset: all state is cleared, registers take their default values and the
// first tick after reset sets the door status from the limit switches.
// stall: the result register holds while result.ready is low; tick.ready
// stays high as long as that register is empty or being emptied this cycle.
module auto_door_controller import adc_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    adc_tick_if.sink                tick,
    adc_result_if.source            result,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    typedef struct packed {
        logic [DUTY_BITS-1:0] cd;
        logic [DUTY_BITS-1:0] od;
        logic [1:0]           ph;
        logic [1:0]           div;
        logic [1:0]           pd;
    } ramp_t;

    // configuration
    logic [15:0] hold_time_reg;
    logic [1:0]  ramp_up_step_reg;
    logic [7:0]  close_down_start_reg;
    logic [1:0]  close_down_step_reg;
    logic [1:0]  open_down_step_reg;

    // door state
    logic                  started_reg, started_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  timer_reg, timer_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  last_a_reg, last_a_next;
    logic                  last_b_reg, last_b_next;
    ramp_t                 ramp_reg, ramp_next;

    logic    res_valid_reg;
    result_t res_reg;
    logic    accept;

    function automatic logic [1:0] eff_step(input logic [1:0] s);
        eff_step = (s == 2'd0) ? 2'd1 : s;
    endfunction

    function automatic ramp_t begin_up(input ramp_t r, input logic [1:0] dir);
        ramp_t n;
        n     = r;
        n.div = 2'd0;
        n.pd  = dir;
        if (dir == DIR_OPEN)
        begin
            n.cd = '0;
            n.ph = (n.od >= DUTY_MAX) ? PH_IDLE : PH_UP;
        end
        else
        begin
            n.od = '0;
            n.ph = (n.cd >= DUTY_MAX) ? PH_IDLE : PH_UP;
        end
        if (n.ph == PH_IDLE)
            n.pd = DIR_NONE;
        begin_up = n;
    endfunction

    function automatic ramp_t cmd_stop(input ramp_t r, input logic [7:0] start);
        ramp_t n;
        n     = r;
        n.pd  = DIR_NONE;
        n.div = 2'd0;
        if (n.cd > start)
            n.cd = start;
        n.ph = (n.cd != '0 || n.od != '0) ? PH_DOWN : PH_IDLE;
        cmd_stop = n;
    endfunction

    function automatic ramp_t cmd_move(input ramp_t r, input logic [1:0] dir);
        ramp_t n;
        n = r;
        if (r.ph == PH_DOWN)
            n.pd = dir;
        else
            n = begin_up(r, dir);
        cmd_move = n;
    endfunction

    function automatic ramp_t advance(input ramp_t r, input logic [1:0] up_step,
                                      input logic [1:0] cl_step,
                                      input logic [1:0] op_step);
        ramp_t                n;
        logic [2:0]           cnt;
        logic [DUTY_BITS-1:0] d;
        logic                 on_close;
        logic [1:0]           st;
        n = r;
        case (r.ph)
            PH_UP:
            begin
                d   = (r.pd == DIR_OPEN) ? r.od : r.cd;
                cnt = {1'b0, r.div} + 3'd1;
                n.div = cnt[1:0];
                if (cnt >= {1'b0, eff_step(up_step)})
                begin
                    n.div = 2'd0;
                    if (d < DUTY_MAX)
                        d = d + 1'b1;
                end
                if (d >= DUTY_MAX)
                begin
                    d     = DUTY_MAX;
                    n.ph  = PH_IDLE;
                    n.div = 2'd0;
                end
                if (r.pd == DIR_OPEN)
                    n.od = d;
                else
                    n.cd = d;
                if (n.ph == PH_IDLE)
                    n.pd = DIR_NONE;
            end
            PH_DOWN:
            begin
                on_close = (r.cd != '0);
                d   = on_close ? r.cd : r.od;
                st  = eff_step(on_close ? cl_step : op_step);
                cnt = {1'b0, r.div} + 3'd1;
                n.div = cnt[1:0];
                if (cnt >= {1'b0, st})
                begin
                    n.div = 2'd0;
                    if (d > '0)
                        d = d - 1'b1;
                end
                if (on_close)
                    n.cd = d;
                else
                    n.od = d;
                if (n.cd == '0 && n.od == '0)
                begin
                    n.div = 2'd0;
                    if (n.pd != DIR_NONE)
                        n = begin_up(n, n.pd);
                    else
                        n.ph = PH_IDLE;
                end
            end
            default:
            begin
                n.ph  = PH_IDLE;
                n.div = 2'd0;
            end
        endcase
        advance = n;
    endfunction

    assign accept      = tick.valid && tick.ready;
    assign tick.ready  = !res_valid_reg || result.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    always_comb
    begin
        ramp_next    = advance(ramp_reg, ramp_up_step_reg, close_down_step_reg,
                               open_down_step_reg);
        elapsed_next = (elapsed_reg < TIMER_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        started_next = started_reg;
        mode_next    = mode_reg;
        timer_next   = timer_reg;
        last_a_next  = last_a_reg;
        last_b_next  = last_b_reg;

        if (!started_reg)
        begin
            started_next = 1'b1;
            if (!tick.data.limit_closed_n)
                mode_next = MODE_CLOSED;
            else if (!tick.data.limit_open_n)
                mode_next = MODE_OPEN;
            else
            begin
                mode_next = MODE_OPENING;
                ramp_next = cmd_move(ramp_next, DIR_OPEN);
            end
        end
        else
        begin
            // a rising edge on either sensor restarts the hold timer
            if ((tick.data.sensor_a && !last_a_reg) || (tick.data.sensor_b && !last_b_reg))
            begin
                timer_next   = 1'b1;
                elapsed_next = '0;
            end
            last_a_next = tick.data.sensor_a;
            last_b_next = tick.data.sensor_b;
            if (elapsed_next > hold_time_reg)
                timer_next = 1'b0;

            if (mode_next == MODE_OPENING && !tick.data.limit_open_n)
            begin
                ramp_next    = cmd_stop(ramp_next, close_down_start_reg);
                mode_next    = MODE_OPEN;
                timer_next   = 1'b1;
                elapsed_next = '0;
            end
            if (mode_next == MODE_OPEN && !timer_next)
            begin
                ramp_next = cmd_move(ramp_next, DIR_CLOSE);
                mode_next = MODE_CLOSING;
            end
            if (mode_next == MODE_CLOSING)
            begin
                if (!tick.data.limit_closed_n)
                begin
                    ramp_next = cmd_stop(ramp_next, close_down_start_reg);
                    mode_next = MODE_CLOSED;
                end
                // reverse while the hold timer runs
                if (timer_next)
                begin
                    ramp_next = cmd_stop(ramp_next, close_down_start_reg);
                    ramp_next = cmd_move(ramp_next, DIR_OPEN);
                    mode_next = MODE_OPENING;
                end
            end
            if (mode_next == MODE_CLOSED && timer_next)
            begin
                ramp_next = cmd_move(ramp_next, DIR_OPEN);
                mode_next = MODE_OPENING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg        <= HOLD_TIME_RST;
            ramp_up_step_reg     <= RAMP_UP_STEP_RST;
            close_down_start_reg <= CLOSE_DOWN_START_RST;
            close_down_step_reg  <= CLOSE_DOWN_STEP_RST;
            open_down_step_reg   <= OPEN_DOWN_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HOLD_TIME:        hold_time_reg        <= cfg_data[15:0];
                CFG_RAMP_UP_STEP:     ramp_up_step_reg     <= cfg_data[1:0];
                CFG_CLOSE_DOWN_START: close_down_start_reg <= cfg_data[7:0];
                CFG_CLOSE_DOWN_STEP:  close_down_step_reg  <= cfg_data[1:0];
                CFG_OPEN_DOWN_STEP:   open_down_step_reg   <= cfg_data[1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            mode_reg      <= MODE_OPEN;
            timer_reg     <= 1'b0;
            elapsed_reg   <= '0;
            last_a_reg    <= 1'b0;
            last_b_reg    <= 1'b0;
            ramp_reg      <= '{cd: '0, od: '0, ph: PH_IDLE, div: 2'd0, pd: DIR_NONE};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                started_reg <= started_next;
                mode_reg    <= mode_next;
                timer_reg   <= timer_next;
                elapsed_reg <= elapsed_next;
                last_a_reg  <= last_a_next;
                last_b_reg  <= last_b_next;
                ramp_reg    <= ramp_next;
            end
            if (accept)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.close_drive_duty <= ramp_next.cd;
            res_reg.open_drive_duty  <= ramp_next.od;
            res_reg.door_status      <= mode_next;
            res_reg.hold_active      <= timer_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_reg.ph == PH_IDLE |-> ramp_reg.pd == DIR_NONE)
        else $error("ramp idle with a pending direction");

    a_up_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_reg.ph == PH_UP |-> (ramp_reg.cd == '0 || ramp_reg.od == '0))
        else $error("both motors driven during ramp up");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted item produced no result");
`endif

endmodule

### bench/tb_top.sv
// self-checking bench for the automatic door controller: random ticks, stalls and settings
module tb_top;
    import adc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    adc_tick_if   tick_ch ();
    adc_result_if res_ch ();

    auto_door_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies as the block holds them
    logic [15:0] hold_cfg;
    logic [1:0]  up_step_cfg;
    logic [7:0]  cdown_start_cfg;
    logic [1:0]  cdown_step_cfg;
    logic [1:0]  odown_step_cfg;

    // door and motor state as predicted
    bit          started;
    logic [1:0]  door_mode;
    bit          timer_on;
    logic [15:0] elapsed;
    bit          prev_a;
    bit          prev_b;
    logic [7:0]  close_d;
    logic [7:0]  open_d;
    logic [1:0]  ramp_ph;
    int unsigned ramp_div;
    logic [1:0]  pend_dir;

    tick_t   pending_ticks[$];
    result_t expected_results[$];

    int  ticks_queued;
    int  ticks_taken;
    int  results_seen;
    int  fail_count;
    bit  tick_taken_flag;
    bit  calm;
    int  stall_left;
    bit  stall_done;

    localparam logic [3:0] DIRECTED [21] = '{
        4'b1111, 4'b1100, 4'b1110, 4'b1101, 4'b1111, 4'b0100, 4'b0100,
        4'b1000, 4'b0000, 4'b0011, 4'b1100, 4'b1100, 4'b1100, 4'b0110,
        4'b1001, 4'b1100, 4'b0010, 4'b1101, 4'b0100, 4'b1011, 4'b0111
    };

    function automatic int unsigned step_of(input logic [1:0] s);
        return (s == 2'd0) ? 1 : s;
    endfunction

    function automatic void motor_start_up(input logic [1:0] dir);
        ramp_div = 0;
        pend_dir = dir;
        if (dir == DIR_OPEN)
        begin
            close_d = 8'd0;
            ramp_ph = (open_d >= DUTY_MAX) ? PH_IDLE : PH_UP;
        end
        else
        begin
            open_d  = 8'd0;
            ramp_ph = (close_d >= DUTY_MAX) ? PH_IDLE : PH_UP;
        end
        if (ramp_ph == PH_IDLE)
            pend_dir = DIR_NONE;
    endfunction

    function automatic void motor_stop();
        pend_dir = DIR_NONE;
        ramp_div = 0;
        if (close_d > cdown_start_cfg)
            close_d = cdown_start_cfg;
        ramp_ph = (close_d != 0 || open_d != 0) ? PH_DOWN : PH_IDLE;
    endfunction

    function automatic void motor_move(input logic [1:0] dir);
        if (ramp_ph == PH_DOWN)
            pend_dir = dir;
        else
            motor_start_up(dir);
    endfunction

    function automatic void motor_ramp_tick();
        logic [7:0]  d;
        bit          sel;
        int unsigned st;
        if (ramp_ph == PH_UP)
        begin
            sel = (pend_dir == DIR_OPEN);
            d = sel ? open_d : close_d;
            ramp_div++;
            if (ramp_div >= step_of(up_step_cfg))
            begin
                ramp_div = 0;
                if (d < DUTY_MAX)
                    d = d + 8'd1;
            end
            if (sel)
                open_d = d;
            else
                close_d = d;
            if (d >= DUTY_MAX)
            begin
                ramp_ph  = PH_IDLE;
                pend_dir = DIR_NONE;
                ramp_div = 0;
            end
        end
        else if (ramp_ph == PH_DOWN)
        begin
            // close motor winds down first while it still runs
            sel = (close_d != 0);
            d = sel ? close_d : open_d;
            st = step_of(sel ? cdown_step_cfg : odown_step_cfg);
            ramp_div++;
            if (ramp_div >= st)
            begin
                ramp_div = 0;
                if (d > 0)
                    d = d - 8'd1;
            end
            if (sel)
                close_d = d;
            else
                open_d = d;
            if (close_d == 0 && open_d == 0)
            begin
                ramp_div = 0;
                if (pend_dir != DIR_NONE)
                    motor_start_up(pend_dir);
                else
                    ramp_ph = PH_IDLE;
            end
        end
        else
        begin
            ramp_ph  = PH_IDLE;
            ramp_div = 0;
        end
    endfunction

    function automatic void hold_restart();
        timer_on = 1'b1;
        elapsed  = '0;
    endfunction

    function automatic result_t next_result(input tick_t t);
        result_t r;
        bit      at_open;
        bit      at_closed;
        at_open   = (t.limit_open_n == 1'b0);
        at_closed = (t.limit_closed_n == 1'b0);
        motor_ramp_tick();
        if (elapsed < TIMER_MAX)
            elapsed = elapsed + 16'd1;
        if (!started)
        begin
            // first tick: mode from the switches only, sensors ignored
            started = 1'b1;
            if (at_closed)
                door_mode = MODE_CLOSED;
            else if (at_open)
                door_mode = MODE_OPEN;
            else
            begin
                door_mode = MODE_OPENING;
                motor_move(DIR_OPEN);
            end
        end
        else
        begin
            if (t.sensor_a && !prev_a)
                hold_restart();
            if (t.sensor_b && !prev_b)
                hold_restart();
            prev_a = t.sensor_a;
            prev_b = t.sensor_b;
            if (elapsed > hold_cfg)
                timer_on = 1'b0;
            if (door_mode == MODE_OPENING && at_open)
            begin
                motor_stop();
                door_mode = MODE_OPEN;
                hold_restart();
            end
            if (door_mode == MODE_OPEN && !timer_on)
            begin
                motor_move(DIR_CLOSE);
                door_mode = MODE_CLOSING;
            end
            if (door_mode == MODE_CLOSING)
            begin
                if (at_closed)
                begin
                    motor_stop();
                    door_mode = MODE_CLOSED;
                end
                if (timer_on)
                begin
                    motor_stop();
                    motor_move(DIR_OPEN);
                    door_mode = MODE_OPENING;
                end
            end
            if (door_mode == MODE_CLOSED && timer_on)
            begin
                motor_move(DIR_OPEN);
                door_mode = MODE_OPENING;
            end
        end
        r.close_drive_duty = close_d;
        r.open_drive_duty  = open_d;
        r.door_status      = door_mode;
        r.hold_active      = timer_on;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // tick driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!tick_ch.valid || tick_taken_flag)
            begin
                tick_taken_flag = 1'b0;
                if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 16))
                begin
                    tick_ch.data  <= pending_ticks.pop_front();
                    tick_ch.valid <= 1'b1;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!stall_done && results_seen >= 150)
            begin
                stall_done = 1'b1;
                stall_left = 59;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // result check first, then prediction of the item taken at this edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, actual %h",
                             $time, res_ch.data);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("close_drive_duty", 32'(want.close_drive_duty),
                                32'(res_ch.data.close_drive_duty));
                    check_field("open_drive_duty", 32'(want.open_drive_duty),
                                32'(res_ch.data.open_drive_duty));
                    check_field("door_status", 32'(want.door_status),
                                32'(res_ch.data.door_status));
                    check_field("hold_active", 32'(want.hold_active),
                                32'(res_ch.data.hold_active));
                end
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                expected_results.push_back(next_result(tick_ch.data));
                ticks_taken++;
                tick_taken_flag = 1'b1;
            end
        end
    end

    task automatic queue_tick(input bit lo_n, input bit lc_n, input bit sa, input bit sb);
        tick_t t;
        t.limit_open_n   = lo_n;
        t.limit_closed_n = lc_n;
        t.sensor_a       = sa;
        t.sensor_b       = sb;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // a stretch with fixed switches and sensors firing pct percent of the ticks
    task automatic queue_segment(input bit lo_n, input bit lc_n, input int len, input int pct);
        for (int i = 0; i < len; i++)
            queue_tick(lo_n, lc_n, $urandom_range(0, 99) < pct, $urandom_range(0, 99) < pct);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (ticks_taken != ticks_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_HOLD_TIME:        hold_cfg        = val;
            CFG_RAMP_UP_STEP:     up_step_cfg     = val[1:0];
            CFG_CLOSE_DOWN_START: cdown_start_cfg = val[7:0];
            CFG_CLOSE_DOWN_STEP:  cdown_step_cfg  = val[1:0];
            CFG_OPEN_DOWN_STEP:   odown_step_cfg  = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] hold, input logic [1:0] up,
                            input logic [7:0] cstart, input logic [1:0] cstep,
                            input logic [1:0] ostep);
        wait_drained();
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_RAMP_UP_STEP, {14'd0, up});
        write_reg(CFG_CLOSE_DOWN_START, {8'd0, cstart});
        write_reg(CFG_CLOSE_DOWN_STEP, {14'd0, cstep});
        write_reg(CFG_OPEN_DOWN_STEP, {14'd0, ostep});
    endtask

    // mostly full door cycles with random timing, some raw switch noise
    task automatic queue_mixed(input int n);
        int start;
        start = ticks_queued;
        while (ticks_queued - start < n)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                queue_segment(1'b1, 1'b1, $urandom_range(3, 40), $urandom_range(0, 12));
                queue_segment(1'b0, 1'b1, $urandom_range(1, 25), $urandom_range(0, 15));
                queue_segment(1'b1, 1'b1, $urandom_range(3, 40), $urandom_range(0, 8));
                queue_segment(1'b1, 1'b0, $urandom_range(1, 20), $urandom_range(0, 10));
            end
            else
            begin
                repeat ($urandom_range(3, 10))
                    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        logic [3:0] v;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.data    = '0;
        res_ch.ready    = 1'b0;
        hold_cfg        = HOLD_TIME_RST;
        up_step_cfg     = RAMP_UP_STEP_RST;
        cdown_start_cfg = CLOSE_DOWN_START_RST;
        cdown_step_cfg  = CLOSE_DOWN_STEP_RST;
        odown_step_cfg  = OPEN_DOWN_STEP_RST;
        started         = 1'b0;
        door_mode       = MODE_OPEN;
        timer_on        = 1'b0;
        elapsed         = '0;
        prev_a          = 1'b0;
        prev_b          = 1'b0;
        close_d         = '0;
        open_d          = '0;
        ramp_ph         = PH_IDLE;
        ramp_div        = 0;
        pend_dir        = DIR_NONE;
        ticks_queued    = 0;
        ticks_taken     = 0;
        results_seen    = 0;
        fail_count      = 0;
        tick_taken_flag = 1'b0;
        calm            = 1'b0;
        stall_left      = 0;
        stall_done      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first tick: switches at random, sensors high but not sampled
        queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
        foreach (DIRECTED[i])
        begin
            v = DIRECTED[i];
            queue_tick(v[3], v[2], v[1], v[0]);
        end

        // long calm stretch: one motor climbs all the way to full duty
        set_regs(16'd4, 2'd1, 8'd0, 2'd0, 2'd1);
        calm = 1'b1;
        queue_segment(1'b1, 1'b1, 280, 0);
        queue_segment(1'b0, 1'b1, 20, 5);
        queue_segment(1'b1, 1'b1, 40, 3);
        queue_segment(1'b1, 1'b0, 20, 3);
        wait_drained();
        calm = 1'b0;

        set_regs(16'd65535, 2'd3, 8'd255, 2'd3, 2'd3);
        queue_mixed(65);
        set_regs(16'd0, 2'd0, 8'd128, 2'd0, 2'd0);
        queue_mixed(65);
        set_regs(16'd1, 2'd3, 8'd0, 2'd1, 2'd3);
        queue_mixed(65);
        set_regs(16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)));
        queue_mixed(65);
        repeat (4)
        begin
            set_regs(16'($urandom_range(1, 40)), 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            queue_mixed(65);
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
